### hw/rtl/bfra_pkg.sv
`default_nettype none
package bfra_pkg;

	localparam int MAX_CHUNKS = 32;
	localparam int IDX_W = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
	localparam int CNT_W = $clog2(MAX_CHUNKS + 1);
	localparam int OFF_W = 24;
	localparam int LEN_W = 25;
	localparam int END_W = LEN_W + 1;
	localparam int ENTRY_W = OFF_W + LEN_W;

	localparam logic [END_W-1:0] POOL_BYTES = END_W'(16777216);

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_TOO_BIG = 2'd1;
	localparam logic [1:0] ST_NO_FIT = 2'd2;
	localparam logic [1:0] ST_FULL = 2'd3;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

endpackage
`default_nettype wire

### hw/rtl/bfra_req_if.sv
`default_nettype none
interface bfra_req_if;
	logic valid;
	logic ready;
	logic op;
	logic [bfra_pkg::LEN_W-1:0] length;
	logic [bfra_pkg::OFF_W-1:0] start_req;

	modport source (output valid, output op, output length, output start_req, input ready);
	modport sink (input valid, input op, input length, input start_req, output ready);
endinterface
`default_nettype wire

### hw/rtl/bfra_rsp_if.sv
`default_nettype none
interface bfra_rsp_if;
	logic valid;
	logic ready;
	logic [1:0] status;
	logic [bfra_pkg::OFF_W-1:0] granted_offset;

	modport source (output valid, output status, output granted_offset, input ready);
	modport sink (input valid, input status, input granted_offset, output ready);
endinterface
`default_nettype wire

### hw/rtl/bfra_ram.sv
`default_nettype none
module bfra_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

### hw/rtl/best_fit_range_allocator.sv
`default_nettype none
// Best-fit range allocator for one byte pool, tracked as a table of free chunks held in a
// small RAM with a valid flip-flop per slot. Each request makes one sequential pass over
// every slot through the single RAM read port, evaluating one entry per cycle, and then
// writes back the updated chunk in the S_WRITE state before its response is offered.
// Requests rejected on range alone, and zero-length releases, skip the pass and go
// straight to the output state. A new request is accepted only while no other request
// is in progress; a finished response waits in an output register and does not block
// the next request.
module best_fit_range_allocator (
	input wire logic clk,
	input wire logic arst_n,
	bfra_req_if.sink req,
	bfra_rsp_if.source rsp
);
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_WRITE = 4'b0100,
		S_OUT = 4'b1000
	} state_t;

	state_t state_q;
	logic [bfra_pkg::CNT_W-1:0] cnt_q;
	logic rd_vld_s1;
	logic [bfra_pkg::IDX_W-1:0] idx_s1;
	logic [bfra_pkg::MAX_CHUNKS-1:0] valid_q;
	logic fresh_q;

	logic op_q;
	logic [bfra_pkg::LEN_W-1:0] len_q;
	logic [bfra_pkg::OFF_W-1:0] start_q;
	logic [bfra_pkg::END_W-1:0] end_q;

	logic found_a_q, found_b_q, free_found_q;
	logic [bfra_pkg::IDX_W-1:0] a_idx_q, b_idx_q, free_idx_q;
	logic [bfra_pkg::OFF_W-1:0] a_start_q;
	logic [bfra_pkg::LEN_W-1:0] a_len_q, b_len_q;

	logic [1:0] res_status_q;
	logic [bfra_pkg::OFF_W-1:0] res_offset_q;
	logic out_vld_q;
	logic [1:0] out_status_q;
	logic [bfra_pkg::OFF_W-1:0] out_offset_q;

	logic ram_we;
	logic [bfra_pkg::IDX_W-1:0] ram_waddr;
	logic [bfra_pkg::ENTRY_W-1:0] ram_wdata;
	logic [bfra_pkg::ENTRY_W-1:0] ram_rdata;

	logic [bfra_pkg::OFF_W-1:0] e_start;
	logic [bfra_pkg::LEN_W-1:0] e_len;
	logic [bfra_pkg::END_W-1:0] e_end;
	logic e_valid;
	logic req_fire;
	logic [bfra_pkg::END_W-1:0] in_end;
	logic [bfra_pkg::LEN_W-1:0] merge_sum;

	bfra_ram #(
		.WIDTH(bfra_pkg::ENTRY_W),
		.DEPTH(bfra_pkg::MAX_CHUNKS)
	) u_table (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(cnt_q[bfra_pkg::IDX_W-1:0]),
		.rdata(ram_rdata)
	);

	assign req.ready = (state_q == S_IDLE);
	assign req_fire = req.valid && req.ready;
	assign in_end = {2'b00, req.start_req} + {1'b0, req.length};

	assign rsp.valid = out_vld_q;
	assign rsp.status = out_status_q;
	assign rsp.granted_offset = out_offset_q;

	// Slot 0 holds the whole pool after reset until it is first written.
	always_comb begin
		if (fresh_q && idx_s1 == '0) begin
			e_start = '0;
			e_len = bfra_pkg::POOL_BYTES[bfra_pkg::LEN_W-1:0];
		end else begin
			e_start = ram_rdata[bfra_pkg::ENTRY_W-1:bfra_pkg::LEN_W];
			e_len = ram_rdata[bfra_pkg::LEN_W-1:0];
		end
		e_valid = valid_q[idx_s1];
		e_end = {2'b00, e_start} + {1'b0, e_len};
	end

	assign merge_sum = a_len_q + len_q + b_len_q;

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = a_idx_q;
		ram_wdata = {a_start_q, a_len_q};
		if (state_q == S_WRITE) begin
			if (op_q == bfra_pkg::OP_ALLOC) begin
				ram_we = found_a_q;
				ram_wdata = {a_start_q + len_q[bfra_pkg::OFF_W-1:0], a_len_q - len_q};
			end else if (found_a_q) begin
				ram_we = 1'b1;
				ram_wdata = {a_start_q, merge_sum};
				if (!found_b_q) begin
					ram_wdata = {a_start_q, a_len_q + len_q};
				end
			end else if (found_b_q) begin
				ram_we = 1'b1;
				ram_waddr = b_idx_q;
				ram_wdata = {start_q, b_len_q + len_q};
			end else begin
				ram_we = free_found_q;
				ram_waddr = free_idx_q;
				ram_wdata = {start_q, len_q};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			rd_vld_s1 <= 1'b0;
			valid_q <= bfra_pkg::MAX_CHUNKS'(1);
			fresh_q <= 1'b1;
			found_a_q <= 1'b0;
			found_b_q <= 1'b0;
			free_found_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (out_vld_q && rsp.ready && state_q != S_OUT) begin
				out_vld_q <= 1'b0;
			end
			if (ram_we && ram_waddr == '0) begin
				fresh_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						found_a_q <= 1'b0;
						found_b_q <= 1'b0;
						free_found_q <= 1'b0;
						cnt_q <= '0;
						rd_vld_s1 <= 1'b0;
						if (req.op == bfra_pkg::OP_ALLOC &&
						    {1'b0, req.length} > bfra_pkg::POOL_BYTES) begin
							state_q <= S_OUT;
						end else if (req.op == bfra_pkg::OP_RELEASE &&
						             (in_end > bfra_pkg::POOL_BYTES || req.length == '0)) begin
							state_q <= S_OUT;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (cnt_q != bfra_pkg::CNT_W'(bfra_pkg::MAX_CHUNKS)) begin
						cnt_q <= cnt_q + bfra_pkg::CNT_W'(1);
						rd_vld_s1 <= 1'b1;
					end else begin
						rd_vld_s1 <= 1'b0;
						if (rd_vld_s1) begin
							state_q <= S_WRITE;
						end
					end
					if (rd_vld_s1) begin
						if (op_q == bfra_pkg::OP_ALLOC) begin
							if (e_valid && e_len >= len_q &&
							    (!found_a_q || e_len < a_len_q ||
							     (e_len == a_len_q && e_start < a_start_q))) begin
								found_a_q <= 1'b1;
							end
						end else if (!e_valid) begin
							if (!free_found_q) begin
								free_found_q <= 1'b1;
							end
						end else if (!found_a_q && e_end == {2'b00, start_q}) begin
							found_a_q <= 1'b1;
						end else if (!found_b_q && {2'b00, e_start} == end_q) begin
							found_b_q <= 1'b1;
						end
					end
				end
				S_WRITE: begin
					if (op_q == bfra_pkg::OP_ALLOC) begin
						if (found_a_q && a_len_q == len_q) begin
							valid_q[a_idx_q] <= 1'b0;
						end
					end else if (found_a_q) begin
						if (found_b_q) begin
							valid_q[b_idx_q] <= 1'b0;
						end
					end else if (!found_b_q && free_found_q) begin
						valid_q[free_idx_q] <= 1'b1;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_vld_q || rsp.ready) begin
						out_vld_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q[bfra_pkg::IDX_W-1:0];
		if (req_fire) begin
			op_q <= req.op;
			len_q <= req.length;
			start_q <= req.start_req;
			end_q <= in_end;
			res_offset_q <= '0;
			if ((req.op == bfra_pkg::OP_ALLOC && {1'b0, req.length} > bfra_pkg::POOL_BYTES) ||
			    (req.op == bfra_pkg::OP_RELEASE && in_end > bfra_pkg::POOL_BYTES)) begin
				res_status_q <= bfra_pkg::ST_TOO_BIG;
			end else begin
				res_status_q <= bfra_pkg::ST_OK;
			end
		end
		if (state_q == S_SCAN && rd_vld_s1) begin
			if (op_q == bfra_pkg::OP_ALLOC) begin
				if (e_valid && e_len >= len_q &&
				    (!found_a_q || e_len < a_len_q ||
				     (e_len == a_len_q && e_start < a_start_q))) begin
					a_idx_q <= idx_s1;
					a_start_q <= e_start;
					a_len_q <= e_len;
				end
			end else if (!e_valid) begin
				if (!free_found_q) begin
					free_idx_q <= idx_s1;
				end
			end else if (!found_a_q && e_end == {2'b00, start_q}) begin
				a_idx_q <= idx_s1;
				a_start_q <= e_start;
				a_len_q <= e_len;
			end else if (!found_b_q && {2'b00, e_start} == end_q) begin
				b_idx_q <= idx_s1;
				b_len_q <= e_len;
			end
		end
		if (state_q == S_WRITE) begin
			if (op_q == bfra_pkg::OP_ALLOC) begin
				if (found_a_q) begin
					res_status_q <= bfra_pkg::ST_OK;
					res_offset_q <= a_start_q;
				end else begin
					res_status_q <= bfra_pkg::ST_NO_FIT;
				end
			end else if (!found_a_q && !found_b_q && !free_found_q) begin
				res_status_q <= bfra_pkg::ST_FULL;
			end else begin
				res_status_q <= bfra_pkg::ST_OK;
			end
		end
		if (state_q == S_OUT && (!out_vld_q || rsp.ready)) begin
			out_status_q <= res_status_q;
			out_offset_q <= res_offset_q;
		end
	end
endmodule
`default_nettype wire
